[hdl/nirf_pkg.sv]
`timescale 1ns / 1ps

package nirf_pkg;

  // Action codes carried in the input word
  localparam logic ACT_EDGE    = 1'b0;
  localparam logic ACT_TIMEOUT = 1'b1;

  // Timing windows in microseconds, both bounds exclusive
  localparam logic [31:0] LEAD_PULSE_LO = 32'd8000;
  localparam logic [31:0] LEAD_PULSE_HI = 32'd10000;
  localparam logic [31:0] LEAD_SPACE_LO = 32'd3500;
  localparam logic [31:0] LEAD_SPACE_HI = 32'd5500;
  localparam logic [31:0] SHORT_LO      = 32'd400;
  localparam logic [31:0] SHORT_HI      = 32'd700;
  localparam logic [31:0] LONG_LO       = 32'd1400;
  localparam logic [31:0] LONG_HI       = 32'd1900;

  localparam int COUNT_W = 8;

  typedef enum logic [1:0] {
    PH_LEAD_PULSE,
    PH_LEAD_SPACE,
    PH_BIT_PULSE,
    PH_BIT_SPACE
  } phase_t;

  typedef struct packed {
    logic        action;
    logic [31:0] edge_time;
    logic        line_level;
  } in_word_t;

  typedef struct packed {
    logic [31:0]        code;
    logic [COUNT_W-1:0] edge_count;
  } out_word_t;

  // Outcome of checking one edge against the window of the current phase
  typedef struct packed {
    logic   ok;
    logic   shift;
    logic   bit_value;
    phase_t phase_next;
  } check_t;

endpackage

[hdl/nirf_window.sv]
`timescale 1ns / 1ps

module nirf_window (
  input  nirf_pkg::phase_t phase,
  input  logic [31:0]      diff,
  input  logic             level,
  output nirf_pkg::check_t chk
);
  import nirf_pkg::*;

  logic in_lead_pulse;
  logic in_lead_space;
  logic in_short;
  logic in_long;

  assign in_lead_pulse = (diff > LEAD_PULSE_LO) && (diff < LEAD_PULSE_HI);
  assign in_lead_space = (diff > LEAD_SPACE_LO) && (diff < LEAD_SPACE_HI);
  assign in_short      = (diff > SHORT_LO) && (diff < SHORT_HI);
  assign in_long       = (diff > LONG_LO) && (diff < LONG_HI);

  always_comb begin
    chk = '{ok: 1'b0, shift: 1'b0, bit_value: 1'b0, phase_next: phase};
    unique case (phase)
      PH_LEAD_PULSE: begin
        if (level && in_lead_pulse) begin
          chk.ok         = 1'b1;
          chk.phase_next = PH_LEAD_SPACE;
        end
      end
      PH_LEAD_SPACE: begin
        if (!level && in_lead_space) begin
          chk.ok         = 1'b1;
          chk.phase_next = PH_BIT_PULSE;
        end
      end
      PH_BIT_PULSE: begin
        if (level && in_short) begin
          chk.ok         = 1'b1;
          chk.phase_next = PH_BIT_SPACE;
        end
      end
      PH_BIT_SPACE: begin
        // short space is a zero, long space is a one
        if (!level && (in_short || in_long)) begin
          chk.ok         = 1'b1;
          chk.shift      = 1'b1;
          chk.bit_value  = in_long;
          chk.phase_next = PH_BIT_PULSE;
        end
      end
      default: begin
        chk.ok = 1'b0;
      end
    endcase
  end

endmodule

[hdl/nirf_frame.sv]
`timescale 1ns / 1ps

module nirf_frame #(
  parameter int EDGE_LIMIT = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  nirf_pkg::in_word_t   item,
  output nirf_pkg::out_word_t  result
);
  import nirf_pkg::*;

  localparam int CW = $clog2(EDGE_LIMIT + 1);
  localparam int XW = (CW > COUNT_W) ? CW : COUNT_W;

  logic [31:0]   prev_time;
  logic [CW-1:0] edges_seen;
  phase_t        phase;
  logic          still_decoding;
  logic [31:0]   shift_code;

  logic [31:0]   diff;
  check_t        chk;
  logic [XW-1:0] count_ext;

  assign diff = item.edge_time - prev_time;

  nirf_window u_window (
    .phase (phase),
    .diff  (diff),
    .level (item.line_level),
    .chk   (chk)
  );

  // Clamp the count to what the output field can carry
  assign count_ext         = XW'(edges_seen);
  assign result.code       = shift_code;
  assign result.edge_count = (count_ext > XW'(255)) ? {COUNT_W{1'b1}}
                                                    : count_ext[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_time      <= '0;
      edges_seen     <= '0;
      phase          <= PH_LEAD_PULSE;
      still_decoding <= 1'b1;
      shift_code     <= '0;
    end else if (step) begin
      if (item.action == ACT_TIMEOUT) begin
        prev_time      <= '0;
        edges_seen     <= '0;
        phase          <= PH_LEAD_PULSE;
        still_decoding <= 1'b1;
        shift_code     <= '0;
      end else if (edges_seen < CW'(EDGE_LIMIT)) begin
        if ((edges_seen != '0) && still_decoding) begin
          phase          <= chk.phase_next;
          still_decoding <= chk.ok;
          if (chk.shift) begin
            shift_code <= {shift_code[30:0], chk.bit_value};
          end
        end
        prev_time  <= item.edge_time;
        edges_seen <= edges_seen + CW'(1);
      end
    end
  end

endmodule

[hdl/nec_ir_frame_decoder.sv]
`timescale 1ns / 1ps

// NEC infrared frame decoder. Each input word is either an IR line edge
// (microsecond timestamp plus the line level at the edge) or a frame timeout.
// Edges are timed against the previous edge and walked through leading pulse,
// leading space, bit pulse and bit space; a short bit space shifts in 0, a
// long one shifts in 1, with the first bit ending up most significant. The
// first edge that misses its window freezes the code, and later edges are only
// counted, up to EDGE_LIMIT. A timeout produces one output word with the code
// and the edge count (clamped to 255) and clears the frame; an edge produces
// no output word. The block takes one word per cycle while no timeout is
// stalled: a word is held in the input register while the frame state is
// updated from it, and a processed timeout loads the output register and
// raises out_valid. The only stall comes from the output register: a
// timeout waits while an earlier result is still held there, edges pass
// regardless.
module nec_ir_frame_decoder #(
  parameter int EDGE_LIMIT = 128
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nirf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nirf_pkg::out_word_t out_data
);
  import nirf_pkg::*;

  logic      in_full;
  in_word_t  in_hold;
  logic      out_free;
  logic      process;
  out_word_t result;

  // Edges never need the output register; a timeout needs it free
  assign out_free = !out_valid || out_ready;
  assign process  = in_full && ((in_hold.action == ACT_EDGE) || out_free);
  assign in_ready = !in_full || process;

  // Input register: hold the accepted word until it is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_data;
    end
  end

  nirf_frame #(
    .EDGE_LIMIT (EDGE_LIMIT)
  ) u_frame (
    .clk    (clk),
    .rst    (rst),
    .step   (process),
    .item   (in_hold),
    .result (result)
  );

  // Output register: load on a processed timeout, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (process && (in_hold.action == ACT_TIMEOUT)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && (in_hold.action == ACT_TIMEOUT)) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  a_out_from_timeout: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(process && (in_hold.action == ACT_TIMEOUT)))
    else $error("output word appeared without a processed timeout");

  a_stall_only_on_output: assert property (@(posedge clk) disable iff (rst)
    (in_full && !process) |-> (out_valid && !out_ready &&
                               (in_hold.action == ACT_TIMEOUT)))
    else $error("input stalled while the output register could take a word");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.edge_count) <= 32'(EDGE_LIMIT)))
    else $error("edge count above the edge limit");
`endif

endmodule
